// ===== hdl/glyph_blit_window_clip_macros.svh =====
// Assertion macros used by the glyph blitter top level.
`ifndef GLYPH_BLIT_WINDOW_CLIP_MACROS_SVH
`define GLYPH_BLIT_WINDOW_CLIP_MACROS_SVH

// The property must hold at every clock edge out of reset.
`define GBWC_ASSERT(lbl, ck, rn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) \
		else $error("glyph blitter assertion failed");

// The expression must never be true at a clock edge out of reset.
`define GBWC_NEVER(lbl, ck, rn, expr) \
	lbl: assert property (@(posedge ck) disable iff (!rn) !(expr)) \
		else $error("glyph blitter forbidden condition seen");

`endif

// ===== hdl/gbwc_pkg.sv =====
// Types and constants shared by the glyph blitter modules.
package gbwc_pkg;

	localparam int unsigned GLYPH_WIDTH  = 8;
	localparam int unsigned GLYPH_HEIGHT = 8;
	localparam int unsigned FIRST_CODE   = 32'h20;
	localparam int unsigned LAST_CODE    = 32'h7E;
	localparam int unsigned NARROW_LINE  = 320;
	localparam int unsigned ROW_SHIFT    = 3;
	localparam int unsigned ADDR_W       = 19;
	localparam int unsigned INDEX_W      = 10;
	localparam int unsigned CFG_IDX_W    = 3;
	localparam int unsigned CFG_DATA_W   = 10;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WIDE_FRAME  = 3'd0,
		CFG_CLIP_LEFT   = 3'd1,
		CFG_CLIP_TOP    = 3'd2,
		CFG_CLIP_RIGHT  = 3'd3,
		CFG_CLIP_BOTTOM = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic       wide_frame;
		logic [9:0] clip_left;
		logic [8:0] clip_top;
		logic [9:0] clip_right;
		logic [8:0] clip_bottom;
	} cfg_t;

	typedef struct packed {
		logic [9:0] pos_x;
		logic [8:0] pos_y;
		logic [7:0] char_code;
		logic [7:0] fg_color;
		logic [7:0] bg_color;
		logic       transparent;
	} draw_item_t;

	typedef struct packed {
		logic               en;
		logic [INDEX_W-1:0] index;
		logic [7:0]         data;
	} font_wr_t;

	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] address;
		logic [7:0]        color;
		logic              write;
		logic              last;
	} pixel_t;

endpackage

// ===== hdl/glyph_blit_window_clip.sv =====
// Top level of the 8x8 glyph blitter with clip window and loadable font store.
// A load transaction gives no pixel and leaves busy low.
// A draw transaction holds busy through a clip check, two base-address
// adds and the 64 pixels on the shared adder; pixels appear one per cycle
// after the adds; a rejected draw holds busy only for the clip check.
// arst_n clears the control state and loads the register reset values; the
// font store is undefined until loaded; the receiver cannot stall.
module glyph_blit_window_clip #(
	parameter int unsigned GLYPH_STORE_DEPTH = 768
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            cfg_write,
	input  logic [gbwc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gbwc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            command,
	input  logic [9:0]                      pos_x,
	input  logic [8:0]                      pos_y,
	input  logic [7:0]                      char_code,
	input  logic [7:0]                      fg_color,
	input  logic [7:0]                      bg_color,
	input  logic                            transparent,
	input  logic [9:0]                      font_index,
	input  logic [7:0]                      font_byte,
	output logic                            pixel_valid,
	output logic [18:0]                     pixel_address,
	output logic [7:0]                      pixel_color,
	output logic                            pixel_write,
	output logic                            last_pixel
);
	import gbwc_pkg::*;

	`include "glyph_blit_window_clip_macros.svh"

	cfg_t               cfg_q;
	draw_item_t         item;
	font_wr_t           font_wr;
	pixel_t             pixel;
	logic               accept;
	logic [INDEX_W-1:0] rd_index;
	logic [7:0]         row_bits;

	assign accept = start && !busy;

	assign item.pos_x       = pos_x;
	assign item.pos_y       = pos_y;
	assign item.char_code   = char_code;
	assign item.fg_color    = fg_color;
	assign item.bg_color    = bg_color;
	assign item.transparent = transparent;

	assign font_wr.en    = accept && command;
	assign font_wr.index = font_index;
	assign font_wr.data  = font_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wide_frame  <= 1'b0;
			cfg_q.clip_left   <= 10'd0;
			cfg_q.clip_top    <= 9'd0;
			cfg_q.clip_right  <= 10'd320;
			cfg_q.clip_bottom <= 9'd240;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				CFG_WIDE_FRAME:  cfg_q.wide_frame  <= cfg_data[0];
				CFG_CLIP_LEFT:   cfg_q.clip_left   <= cfg_data;
				CFG_CLIP_TOP:    cfg_q.clip_top    <= cfg_data[8:0];
				CFG_CLIP_RIGHT:  cfg_q.clip_right  <= cfg_data;
				CFG_CLIP_BOTTOM: cfg_q.clip_bottom <= cfg_data[8:0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	gbwc_font_mem #(
		.DEPTH (GLYPH_STORE_DEPTH)
	) u_font_mem (
		.clk      (clk),
		.wr       (font_wr),
		.rd_index (rd_index),
		.rd_data  (row_bits)
	);

	gbwc_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.draw_go  (accept && !command),
		.item     (item),
		.cfg      (cfg_q),
		.row_bits (row_bits),
		.rd_index (rd_index),
		.busy     (busy),
		.pixel    (pixel)
	);

	assign pixel_valid   = pixel.valid;
	assign pixel_address = pixel.address;
	assign pixel_color   = pixel.color;
	assign pixel_write   = pixel.write;
	assign last_pixel    = pixel.last;

	// A glyph's pixels come in one unbroken run, and busy covers all but the last.
	`GBWC_ASSERT(a_run_unbroken, clk, arst_n, pixel_valid && !last_pixel |=> pixel_valid)
	`GBWC_ASSERT(a_busy_in_run, clk, arst_n, pixel_valid && !last_pixel |-> busy)
	`GBWC_NEVER(a_last_alone, clk, arst_n, last_pixel && !pixel_valid)
	`GBWC_NEVER(a_skip_colored, clk, arst_n, pixel_valid && !pixel_write && (pixel_color != 8'd0))

endmodule

// ===== hdl/gbwc_font_mem.sv =====
// Glyph row store: one write port and one registered read port.
module gbwc_font_mem #(
	parameter int unsigned DEPTH = 768
) (
	input  logic                      clk,
	input  gbwc_pkg::font_wr_t        wr,
	input  logic [gbwc_pkg::INDEX_W-1:0] rd_index,
	output logic [7:0]                rd_data
);
	import gbwc_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [7:0] mem_q [DEPTH];
	logic       wr_in_range;

	assign wr_in_range = ({1'b0, wr.index} < (INDEX_W + 1)'(DEPTH));

	always_ff @(posedge clk) begin
		if (wr.en && wr_in_range) begin
			mem_q[AW'(wr.index)] <= wr.data;
		end
		rd_data <= mem_q[AW'(rd_index)];
	end

endmodule

// ===== hdl/gbwc_adder.sv =====
// Shared address adder used by the sequencer for the base and every pixel step.
module gbwc_adder (
	input  logic [gbwc_pkg::ADDR_W-1:0] a,
	input  logic [gbwc_pkg::ADDR_W-1:0] b,
	output logic [gbwc_pkg::ADDR_W-1:0] sum
);
	import gbwc_pkg::*;

	assign sum = a + b;

endmodule

// ===== hdl/gbwc_seq.sv =====
// Draw sequencer: clip check, base address build and the 64 pixel steps.
module gbwc_seq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         draw_go,
	input  gbwc_pkg::draw_item_t         item,
	input  gbwc_pkg::cfg_t               cfg,
	input  logic [7:0]                   row_bits,
	output logic [gbwc_pkg::INDEX_W-1:0] rd_index,
	output logic                         busy,
	output gbwc_pkg::pixel_t             pixel
);
	import gbwc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_BASE_Y,
		ST_BASE_X,
		ST_PIXEL
	} state_t;

	state_t            state_q;
	draw_item_t        item_q;
	logic [ADDR_W-1:0] acc_q;
	logic [5:0]        cnt_q;
	logic [6:0]        glyph;
	logic [2:0]        row;
	logic [2:0]        col;
	logic              reject;
	logic              bit_set;
	logic [ADDR_W-1:0] add_a;
	logic [ADDR_W-1:0] add_b;
	logic [ADDR_W-1:0] add_sum;
	logic [ADDR_W-1:0] row_step;

	assign glyph = 7'(item_q.char_code - 8'(FIRST_CODE));
	assign row   = cnt_q[5:3];
	assign col   = cnt_q[2:0];
	assign busy  = (state_q != ST_IDLE);
	assign bit_set = row_bits[col];

	assign reject = (item_q.char_code < 8'(FIRST_CODE)) ||
		(item_q.char_code > 8'(LAST_CODE)) ||
		(item_q.pos_x < cfg.clip_left) ||
		(item_q.pos_y < cfg.clip_top) ||
		(({1'b0, item_q.pos_x} + 11'(GLYPH_WIDTH)) > {1'b0, cfg.clip_right}) ||
		(({1'b0, item_q.pos_y} + 10'(GLYPH_HEIGHT)) > {1'b0, cfg.clip_bottom});

	// Moving from the last column of a row to the first column of the next.
	assign row_step = cfg.wide_frame ? ADDR_W'(2 * NARROW_LINE - GLYPH_WIDTH + 1)
		: ADDR_W'(NARROW_LINE - GLYPH_WIDTH + 1);

	// The next row is fetched during the last column so its bits are ready in time.
	always_comb begin
		rd_index = {glyph, 3'd0};
		if (state_q == ST_PIXEL) begin
			rd_index = (col == 3'd7) ? {glyph, 3'(row + 3'd1)} : {glyph, row};
		end
	end

	always_comb begin
		add_a = acc_q;
		add_b = '0;
		case (state_q)
			ST_BASE_Y: begin
				// 320 = 256 + 64, and 640 is twice that.
				add_a = cfg.wide_frame ? (ADDR_W'(item_q.pos_y) << 9)
					: (ADDR_W'(item_q.pos_y) << 8);
				add_b = cfg.wide_frame ? (ADDR_W'(item_q.pos_y) << 7)
					: (ADDR_W'(item_q.pos_y) << 6);
			end
			ST_BASE_X: begin
				add_b = ADDR_W'(item_q.pos_x);
			end
			ST_PIXEL: begin
				add_b = (col == 3'd7) ? row_step : ADDR_W'(1);
			end
			default: begin
				add_b = '0;
			end
		endcase
	end

	gbwc_adder u_adder (
		.a   (add_a),
		.b   (add_b),
		.sum (add_sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			pixel   <= '0;
		end else begin
			pixel.valid <= 1'b0;
			pixel.last  <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (draw_go) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					state_q <= reject ? ST_IDLE : ST_BASE_Y;
				end
				ST_BASE_Y: begin
					state_q <= ST_BASE_X;
				end
				ST_BASE_X: begin
					cnt_q   <= '0;
					state_q <= ST_PIXEL;
				end
				ST_PIXEL: begin
					pixel.valid   <= 1'b1;
					pixel.last    <= (cnt_q == 6'd63);
					pixel.address <= acc_q;
					pixel.write   <= bit_set || !item_q.transparent;
					pixel.color   <= bit_set ? item_q.fg_color
						: (item_q.transparent ? 8'd0 : item_q.bg_color);
					cnt_q         <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Item capture and the accumulator carry no reset.
	always_ff @(posedge clk) begin
		if (draw_go && (state_q == ST_IDLE)) begin
			item_q <= item;
		end
		if ((state_q == ST_BASE_Y) || (state_q == ST_BASE_X) || (state_q == ST_PIXEL)) begin
			acc_q <= add_sum;
		end
	end

endmodule
